@@ sv/sbmt_pkg.sv @@
package sbmt_pkg;

   localparam int OFFSET_W = 34;
   localparam int LEN_W = 21;
   localparam int BADDR_W = 48;
   localparam int ENTRY_W = 16;
   localparam int INDEX_W = 13;
   localparam int SHIFT_W = 5;
   localparam int MBLK_W = 14;
   localparam int STATUS_W = 3;
   localparam int MIN_SHIFT = 15;
   localparam int INBLK_W = 31;
   localparam int BLK_W = OFFSET_W - MIN_SHIFT;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic OP_MAP_WRITE = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_DISC = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND_MAP = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNMAPPED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BACKING_OVERRUN = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAPPED_BLOCKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISC_SIZE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STORE_SIZE = 2'd3;

   localparam logic [SHIFT_W-1:0] SECTOR_SHIFT_RESET = 5'd21;
   localparam logic [OFFSET_W-1:0] DISC_SIZE_RESET = 34'd9399975936;

   typedef struct packed {
      logic                opcode;
      logic [INDEX_W-1:0]  map_index;
      logic [ENTRY_W-1:0]  map_entry;
      logic [OFFSET_W-1:0] read_offset;
      logic [LEN_W-1:0]    read_length;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BADDR_W-1:0]  backing_address;
      logic [LEN_W-1:0]    chunk_length;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [SHIFT_W-1:0]  sector_shift;
      logic [MBLK_W-1:0]   mapped_blocks;
      logic [OFFSET_W-1:0] disc_size;
      logic [BADDR_W-1:0]  store_size;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_MAP_WRITE,
      KIND_DISC_ERROR,
      KIND_ZERO_LENGTH,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [INDEX_W-1:0]  map_index;
      logic [ENTRY_W-1:0]  map_entry;
      logic [OFFSET_W-1:0] read_offset;
      logic [LEN_W-1:0]    read_length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ sv/sparse_block_map_translate_unit.sv @@
// Sparse block map address translation unit.
// Requests enter on the req_ channel (req_valid, req_stall, req_data). A map-write
// request stores one 16-bit backing sector number and gives no result. A read
// request is split at mapped-sector boundaries and gives one result per chunk on
// the rsp_ channel, the final one marked by last; the first failure ends the read
// with a single error result. Registers are written on the csr_ port, which is
// always ready; the user must write them only while the unit is idle, since the
// unit itself does not enforce this. An accepted request is registered by the
// front classifier and passes through a four-entry queue to the back sequencer.
// The back sequencer answers a front-rejected or zero-length read in its idle
// state; any other read is pulled from the queue there, and each chunk then
// passes the lookup state (map memory read) and the check state (address build
// and backing check). A map write is taken from the queue in the idle state too.
// Reset clears the control state and restores the register defaults; the block
// map holds no defined contents until written. While rsp_stall holds a valid
// result, the result register holds, the sequencer waits to give its next result
// (map writes still drain), and the queue fills until req_stall rises.
module sparse_block_map_translate_unit #(
   parameter int MAP_DEPTH = 8192,
   parameter int MAX_READ_LEN = 1048576
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sbmt_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sbmt_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbmt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sbmt_pkg::BADDR_W-1:0]        csr_wdata
);
   import sbmt_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push_valid;
   cmd_type          push_data;
   cmd_type          head_data;
   queue_status_type q_status;
   logic             pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SECTOR_SHIFT:  cfg_in.sector_shift = csr_wdata[SHIFT_W-1:0];
            CSR_MAPPED_BLOCKS: cfg_in.mapped_blocks = csr_wdata[MBLK_W-1:0];
            CSR_DISC_SIZE:     cfg_in.disc_size = csr_wdata[OFFSET_W-1:0];
            CSR_STORE_SIZE:    cfg_in.store_size = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{SECTOR_SHIFT_RESET, '0, DISC_SIZE_RESET, '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbmt_front #(
      .MAX_READ_LEN(MAX_READ_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push_valid(push_valid),
      .push_data (push_data)
   );

   sbmt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (q_status)
   );

   sbmt_back #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_data(head_data),
      .q_status (q_status),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

@@ sv/sbmt_front.sv @@
module sbmt_front #(
   parameter int MAX_READ_LEN = 1048576
) (
   input  logic             clock,
   input  logic             reset,
   input  sbmt_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbmt_pkg::req_type req_data,
   input  sbmt_pkg::queue_status_type q_status,
   output logic             push_valid,
   output sbmt_pkg::cmd_type push_data
);
   import sbmt_pkg::*;

   localparam int MRL_W = $clog2(MAX_READ_LEN + 1);
   localparam int CMP_W = (MRL_W > LEN_W) ? MRL_W : LEN_W;

   logic          valid_ff, valid_in;
   cmd_type       cmd_ff, cmd_in;
   logic          accept;
   logic          push;
   logic [CMP_W-1:0] len_ext;
   logic [CMP_W-1:0] max_len;
   logic [OFFSET_W-1:0] disc_room;
   logic          disc_error;

   assign req_stall = valid_ff && q_status.full;
   assign accept = req_valid && !req_stall;
   assign push = valid_ff && !q_status.full;

   always_comb begin
      len_ext = CMP_W'(req_data.read_length);
      max_len = CMP_W'(MAX_READ_LEN);
      disc_room = cfg.disc_size - req_data.read_offset;
      disc_error = (len_ext > max_len) || (req_data.read_offset > cfg.disc_size) ||
                   (OFFSET_W'(req_data.read_length) > disc_room);

      cmd_in.map_index = req_data.map_index;
      cmd_in.map_entry = req_data.map_entry;
      cmd_in.read_offset = req_data.read_offset;
      cmd_in.read_length = req_data.read_length;
      if (req_data.opcode == OP_MAP_WRITE) begin
         cmd_in.kind = KIND_MAP_WRITE;
      end else if (disc_error) begin
         cmd_in.kind = KIND_DISC_ERROR;
      end else if (req_data.read_length == '0) begin
         cmd_in.kind = KIND_ZERO_LENGTH;
      end else begin
         cmd_in.kind = KIND_READ;
      end

      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = push;
   assign push_data = cmd_ff;

endmodule

@@ sv/sbmt_queue.sv @@
module sbmt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sbmt_pkg::cmd_type push_data,
   input  logic              pop,
   output sbmt_pkg::cmd_type head_data,
   output sbmt_pkg::queue_status_type status
);
   import sbmt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slots_ff[rd_ptr_ff];
   assign status.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ sv/sbmt_back.sv @@
module sbmt_back #(
   parameter int MAP_DEPTH = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  sbmt_pkg::cfg_type cfg,
   input  sbmt_pkg::cmd_type head_data,
   input  sbmt_pkg::queue_status_type q_status,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sbmt_pkg::rsp_type rsp_data
);
   import sbmt_pkg::*;

   localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int LIM_W = $clog2(MAP_DEPTH + 1);
   localparam int CMP_W = (LIM_W > BLK_W) ? LIM_W : BLK_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [INBLK_W-1:0]  in_block_ff, in_block_in;
   logic [LEN_W-1:0]    count_ff, count_in;

   logic [ENTRY_W-1:0]  map_mem [MAP_DEPTH];
   logic [ENTRY_W-1:0]  entry_ff;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;

   logic                out_free;
   logic [SHIFT_W-1:0]  shift;
   logic [OFFSET_W-1:0] sector;
   logic [OFFSET_W-1:0] in_block_full;
   logic [OFFSET_W-1:0] room;
   logic [LEN_W-1:0]    count;
   logic [CMP_W-1:0]    block_ext;
   logic [CMP_W-1:0]    depth_c;
   logic [CMP_W-1:0]    blocks_ext;
   logic [CMP_W-1:0]    limit;
   logic [CMP_W-1:0]    index_ext;
   logic [BADDR_W-1:0]  addr;
   logic [BADDR_W-1:0]  backing_room;
   logic                overrun;
   logic [LEN_W-1:0]    len_left;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      shift = (cfg.sector_shift < SHIFT_W'(MIN_SHIFT)) ? SHIFT_W'(MIN_SHIFT) : cfg.sector_shift;
      sector = OFFSET_W'(1) << shift;
      in_block_full = offset_ff & (sector - OFFSET_W'(1));
      room = sector - in_block_full;
      count = (room > OFFSET_W'(len_ff)) ? len_ff : room[LEN_W-1:0];
      block_ext = CMP_W'(offset_ff >> shift);
      depth_c = CMP_W'(MAP_DEPTH);
      blocks_ext = CMP_W'(cfg.mapped_blocks);
      limit = (blocks_ext < depth_c) ? blocks_ext : depth_c;
      index_ext = CMP_W'(head_data.map_index);
      addr = (BADDR_W'(entry_ff) << shift) | BADDR_W'(in_block_ff);
      backing_room = cfg.store_size - addr;
      overrun = (addr > cfg.store_size) || (BADDR_W'(count_ff) > backing_room);
      len_left = len_ff - count_ff;

      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      offset_in = offset_ff;
      len_in = len_ff;
      in_block_in = in_block_ff;
      count_in = count_ff;
      pop = 1'b0;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = index_ext[AW-1:0];
      mem_raddr = block_ext[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               case (head_data.kind)
                  KIND_MAP_WRITE: begin
                     pop = 1'b1;
                     mem_we = (index_ext < depth_c);
                  end
                  KIND_DISC_ERROR: begin
                     if (out_free) begin
                        pop = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in = '{STATUS_OUT_OF_DISC, '0, '0, 1'b1};
                     end
                  end
                  KIND_ZERO_LENGTH: begin
                     if (out_free) begin
                        pop = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_data_in = '{STATUS_OK, '0, '0, 1'b1};
                     end
                  end
                  KIND_READ: begin
                     pop = 1'b1;
                     offset_in = head_data.read_offset;
                     len_in = head_data.read_length;
                     state_in = ST_LOOKUP;
                  end
                  default: begin
                     pop = 1'b0;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (block_ext >= limit) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '{STATUS_BEYOND_MAP, '0, '0, 1'b1};
                  state_in = ST_IDLE;
               end
            end else begin
               mem_re = 1'b1;
               in_block_in = in_block_full[INBLK_W-1:0];
               count_in = count;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (entry_ff == '0) begin
                  rsp_data_in = '{STATUS_UNMAPPED, '0, '0, 1'b1};
                  state_in = ST_IDLE;
               end else if (overrun) begin
                  rsp_data_in = '{STATUS_BACKING_OVERRUN, '0, '0, 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  rsp_data_in = '{STATUS_OK, addr, count_ff, (len_left == '0)};
                  offset_in = offset_ff + OFFSET_W'(count_ff);
                  len_in = len_left;
                  state_in = (len_left == '0) ? ST_IDLE : ST_LOOKUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      offset_ff <= offset_in;
      len_ff <= len_in;
      in_block_ff <= in_block_in;
      count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= head_data.map_entry;
      end
      if (mem_re) begin
         entry_ff <= map_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |-> rsp_data_ff.last)
      else $error("error result without last");

   a_error_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != STATUS_OK) |->
      (rsp_data_ff.backing_address == '0) && (rsp_data_ff.chunk_length == '0))
      else $error("error result carries address or length");

   a_middle_chunk_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_OK) && !rsp_data_ff.last |->
      (rsp_data_ff.chunk_length != '0))
      else $error("empty chunk in the middle of a read");

   a_check_follows_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |->
      ($past(state_ff) == ST_LOOKUP) || ($past(state_ff) == ST_CHECK))
      else $error("map check without a lookup");

endmodule

@@ tb/sparse_block_map_translate_unit_test.sv @@
`timescale 1ns / 100ps

module sparse_block_map_translate_unit_test;
   import sbmt_pkg::*;

   localparam int MAP_DEPTH = 8192;
   localparam int MAX_READ_LEN = 1048576;
   localparam int REQUEST_TARGET = 260;
   localparam int PHASES = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [63:0] DISC_MAX = 64'h3_FFFF_FFFF;
   localparam logic [63:0] BACKING_MAX = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] LAST_BLOCK_OFFSET = 64'd8191 * 64'd32768;

   typedef struct {
      bit                     is_config;
      logic [CSR_INDEX_W-1:0] csr_index;
      logic [BADDR_W-1:0]     csr_value;
      req_type                request;
      bit                     typed;
      logic [STATUS_W-1:0]    typed_status;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BADDR_W-1:0] csr_wdata = '0;

   cfg_type shadow;
   logic [ENTRY_W-1:0] block_map [MAP_DEPTH];
   bit map_loaded [MAP_DEPTH];
   rsp_type expected_chunks [$];
   script_row_type script [$];
   int failures = 0;
   int sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;
   bit calm = 1'b0;

   sparse_block_map_translate_unit #(
      .MAP_DEPTH(MAP_DEPTH),
      .MAX_READ_LEN(MAX_READ_LEN)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0 && idle_on && !calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chunks.size() == 0) begin
            $error("unexpected result: %p", rsp_data);
            failures++;
         end else begin
            want = expected_chunks.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.backing_address !== want.backing_address) begin
               $error("backing_address: expected %0h, actual %0h",
                      want.backing_address, rsp_data.backing_address);
               failures++;
            end
            if (rsp_data.chunk_length !== want.chunk_length) begin
               $error("chunk_length: expected %0d, actual %0d",
                      want.chunk_length, rsp_data.chunk_length);
               failures++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   function automatic int sector_bits();
      if (shadow.sector_shift < MIN_SHIFT) begin
         return MIN_SHIFT;
      end
      return int'(shadow.sector_shift);
   endfunction

   function automatic logic [63:0] map_limit();
      if (shadow.mapped_blocks > MAP_DEPTH) begin
         return 64'(MAP_DEPTH);
      end
      return 64'(shadow.mapped_blocks);
   endfunction

   function automatic rsp_type closing_result(input logic [STATUS_W-1:0] status);
      rsp_type r;
      r.status = status;
      r.backing_address = '0;
      r.chunk_length = '0;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic req_type scrambled_request();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic void translate_read(input req_type r);
      logic [63:0] offset, len, disc, sector, limit, blk, in_blk, count, entry, addr, backing;
      int sh;
      rsp_type chunk;
      offset = 64'(r.read_offset);
      len = 64'(r.read_length);
      disc = 64'(shadow.disc_size);
      backing = 64'(shadow.store_size);
      if (len > MAX_READ_LEN || offset > disc || len > disc - offset) begin
         expected_chunks.push_back(closing_result(STATUS_OUT_OF_DISC));
         return;
      end
      if (len == 0) begin
         expected_chunks.push_back(closing_result(STATUS_OK));
         return;
      end
      sh = sector_bits();
      sector = 64'd1 << sh;
      limit = map_limit();
      while (len != 0) begin
         blk = offset >> sh;
         in_blk = offset & (sector - 1);
         count = sector - in_blk;
         if (count > len) begin
            count = len;
         end
         if (blk >= limit) begin
            expected_chunks.push_back(closing_result(STATUS_BEYOND_MAP));
            return;
         end
         entry = 64'(block_map[blk[INDEX_W-1:0]]);
         if (entry == 0) begin
            expected_chunks.push_back(closing_result(STATUS_UNMAPPED));
            return;
         end
         addr = entry * sector + in_blk;
         if (addr > backing || count > backing - addr) begin
            expected_chunks.push_back(closing_result(STATUS_BACKING_OVERRUN));
            return;
         end
         len -= count;
         offset += count;
         chunk.status = STATUS_OK;
         chunk.backing_address = addr[BADDR_W-1:0];
         chunk.chunk_length = count[LEN_W-1:0];
         chunk.last = (len == 0);
         expected_chunks.push_back(chunk);
      end
   endfunction

   task automatic send_request(input req_type r, input bit typed,
                               input logic [STATUS_W-1:0] typed_status);
      int gap;
      if (idle_on && !calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (typed) begin
         expected_chunks.push_back(closing_result(typed_status));
      end else if (r.opcode == OP_MAP_WRITE) begin
         block_map[r.map_index] = r.map_entry;
         map_loaded[r.map_index] = 1'b1;
      end else begin
         translate_read(r);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [BADDR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_SECTOR_SHIFT: shadow.sector_shift = value[SHIFT_W-1:0];
         CSR_MAPPED_BLOCKS: shadow.mapped_blocks = value[MBLK_W-1:0];
         CSR_DISC_SIZE: shadow.disc_size = value[OFFSET_W-1:0];
         default: shadow.store_size = value[BADDR_W-1:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Every map entry that a read can reach is written before the read goes out.
   task automatic load_span(input req_type r);
      logic [63:0] off, len, disc, first_blk, last_blk, lim, b;
      int sh;
      req_type w;
      off = 64'(r.read_offset);
      len = 64'(r.read_length);
      disc = 64'(shadow.disc_size);
      if (len == 0 || len > MAX_READ_LEN || off > disc || len > disc - off) begin
         return;
      end
      sh = sector_bits();
      lim = map_limit();
      first_blk = off >> sh;
      last_blk = (off + len - 1) >> sh;
      for (b = first_blk; b <= last_blk && b < lim; b++) begin
         if (!map_loaded[b[INDEX_W-1:0]]) begin
            w = scrambled_request();
            w.opcode = OP_MAP_WRITE;
            w.map_index = b[INDEX_W-1:0];
            w.map_entry = ($urandom_range(0, 11) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            send_request(w, 1'b0, STATUS_OK);
         end
      end
   endtask

   task automatic pick_config(input bit roomy);
      logic [63:0] sector, v;
      int sh;
      if (roomy) begin
         write_csr(CSR_SECTOR_SHIFT, $urandom_range(15, 16));
         write_csr(CSR_MAPPED_BLOCKS, MAP_DEPTH);
         write_csr(CSR_DISC_SIZE, DISC_MAX);
         write_csr(CSR_STORE_SIZE, BACKING_MAX);
         return;
      end
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 14);
         1: v = 31;
         2, 3: v = $urandom_range(18, 30);
         default: v = $urandom_range(15, 17);
      endcase
      write_csr(CSR_SECTOR_SHIFT, v);
      sh = sector_bits();
      sector = 64'd1 << sh;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = $urandom_range(MAP_DEPTH + 1, 16383);
         2: v = MAP_DEPTH;
         3, 4, 5: v = $urandom_range(1, 64);
         default: v = $urandom_range(1, MAP_DEPTH);
      endcase
      write_csr(CSR_MAPPED_BLOCKS, v);
      case ($urandom_range(0, 9))
         7: v = {$urandom, $urandom} & DISC_MAX;
         8: v = $urandom_range(0, 1 << 20);
         default: v = DISC_MAX;
      endcase
      write_csr(CSR_DISC_SIZE, v);
      case ($urandom_range(0, 9))
         6: v = {$urandom, $urandom} & BACKING_MAX;
         7: v = 0;
         8, 9: v = ((64'($urandom_range(1, 65535)) << sh) + ({$urandom, $urandom} & (sector - 1)))
                   & BACKING_MAX;
         default: v = BACKING_MAX;
      endcase
      write_csr(CSR_STORE_SIZE, v);
   endtask

   task automatic random_step();
      req_type r;
      logic [63:0] sector, lim, reach, span, b, len;
      int sh, pick;
      r = scrambled_request();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.opcode = OP_MAP_WRITE;
         send_request(r, 1'b0, STATUS_OK);
         return;
      end
      r.opcode = OP_READ;
      if (pick >= 18) begin
         sh = sector_bits();
         sector = 64'd1 << sh;
         lim = map_limit();
         reach = 64'd1 << (OFFSET_W - sh);
         span = (lim < reach) ? lim : reach;
         if (span == 0) begin
            b = 0;
         end else begin
            case ($urandom_range(0, 9))
               0: b = span - 1;
               1, 2, 3: b = $urandom_range(0, int'(span) - 1);
               default: b = $urandom_range(0, ((span < 64) ? int'(span) : 64) - 1);
            endcase
         end
         r.read_offset = OFFSET_W'((b << sh) | ({$urandom, $urandom} & (sector - 1)));
         case ($urandom_range(0, 9))
            5, 6: len = $urandom_range(1, 4096);
            7: len = MAX_READ_LEN;
            8: len = 0;
            9: len = $urandom_range(0, (1 << LEN_W) - 1);
            default: len = $urandom_range(1, (3 * sector > MAX_READ_LEN) ?
                                             MAX_READ_LEN : int'(3 * sector));
         endcase
         r.read_length = len[LEN_W-1:0];
      end
      load_span(r);
      send_request(r, 1'b0, STATUS_OK);
   endtask

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] index,
                                   input logic [63:0] value);
      script_row_type row;
      row.is_config = 1'b1;
      row.csr_index = index;
      row.csr_value = value[BADDR_W-1:0];
      row.request = '0;
      row.typed = 1'b0;
      row.typed_status = STATUS_OK;
      script.push_back(row);
   endfunction

   function automatic void add_map(input int index, input int entry);
      script_row_type row;
      row.is_config = 1'b0;
      row.csr_index = CSR_SECTOR_SHIFT;
      row.csr_value = '0;
      row.request = '0;
      row.request.opcode = OP_MAP_WRITE;
      row.request.map_index = index[INDEX_W-1:0];
      row.request.map_entry = entry[ENTRY_W-1:0];
      row.typed = 1'b0;
      row.typed_status = STATUS_OK;
      script.push_back(row);
   endfunction

   function automatic void add_read(input logic [63:0] offset, input logic [63:0] len,
                                    input bit typed, input logic [STATUS_W-1:0] status);
      script_row_type row;
      row.is_config = 1'b0;
      row.csr_index = CSR_SECTOR_SHIFT;
      row.csr_value = '0;
      row.request = '0;
      row.request.opcode = OP_READ;
      row.request.read_offset = offset[OFFSET_W-1:0];
      row.request.read_length = len[LEN_W-1:0];
      row.typed = typed;
      row.typed_status = status;
      script.push_back(row);
   endfunction

   initial begin
      bit configuring;
      int phase;
      shadow.sector_shift = SECTOR_SHIFT_RESET;
      shadow.mapped_blocks = '0;
      shadow.disc_size = DISC_SIZE_RESET;
      shadow.store_size = '0;
      foreach (map_loaded[i]) begin
         map_loaded[i] = 1'b0;
         block_map[i] = '0;
      end

      add_read(0, 0, 1'b1, STATUS_OK);
      add_read(DISC_SIZE_RESET, 0, 1'b1, STATUS_OK);
      add_read(DISC_SIZE_RESET, 1, 1'b1, STATUS_OUT_OF_DISC);
      add_read(DISC_MAX, (1 << LEN_W) - 1, 1'b1, STATUS_OUT_OF_DISC);
      add_read(0, MAX_READ_LEN + 1, 1'b1, STATUS_OUT_OF_DISC);
      add_read(0, MAX_READ_LEN, 1'b1, STATUS_BEYOND_MAP);
      add_csr(CSR_SECTOR_SHIFT, 0);
      add_csr(CSR_MAPPED_BLOCKS, 16383);
      add_csr(CSR_DISC_SIZE, DISC_MAX);
      add_csr(CSR_STORE_SIZE, BACKING_MAX);
      add_map(0, 65535);
      add_map(MAP_DEPTH - 1, 1);
      add_map(1, 0);
      add_read(5, 32768, 1'b0, STATUS_OK);
      add_read(LAST_BLOCK_OFFSET + 10, 32768, 1'b0, STATUS_OK);
      add_read(LAST_BLOCK_OFFSET, 32768, 1'b0, STATUS_OK);
      add_read(32768, 1, 1'b1, STATUS_UNMAPPED);
      add_read(DISC_MAX, 1, 1'b1, STATUS_OUT_OF_DISC);
      add_read(DISC_MAX, 0, 1'b1, STATUS_OK);
      add_csr(CSR_SECTOR_SHIFT, 31);
      add_read(0, MAX_READ_LEN, 1'b0, STATUS_OK);
      add_read(64'd1 << 31, 1, 1'b1, STATUS_UNMAPPED);
      add_csr(CSR_SECTOR_SHIFT, 15);
      add_csr(CSR_STORE_SIZE, 64'd2147483647);
      add_read(0, 32767, 1'b0, STATUS_OK);
      add_read(0, 32768, 1'b1, STATUS_BACKING_OVERRUN);
      add_read(LAST_BLOCK_OFFSET, 1, 1'b0, STATUS_OK);
      add_csr(CSR_DISC_SIZE, 0);
      add_csr(CSR_MAPPED_BLOCKS, 0);
      add_read(0, 0, 1'b1, STATUS_OK);
      add_read(0, 1, 1'b1, STATUS_OUT_OF_DISC);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configuring = 1'b0;
      foreach (script[i]) begin
         if (script[i].is_config) begin
            if (!configuring) begin
               settle();
            end
            configuring = 1'b1;
            write_csr(script[i].csr_index, script[i].csr_value);
         end else begin
            configuring = 1'b0;
            send_request(script[i].request, script[i].typed, script[i].typed_status);
         end
      end

      sent = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         calm = (phase == PHASES - 1);
         idle_on = ($urandom_range(0, 3) != 0);
         pick_config(calm);
         while (sent < (phase + 1) * REQUEST_TARGET / PHASES) begin
            random_step();
         end
      end
      settle();

      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sbmt_pkg.sv
sv/sbmt_front.sv
sv/sbmt_queue.sv
sv/sbmt_back.sv
sv/sparse_block_map_translate_unit.sv
tb/sparse_block_map_translate_unit_test.sv
